>>> rtl/core/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tccw_pkg.sv
// Package for the text console character writer: payload types, codes, state enum.
// No dependencies.
`timescale 1ns / 1ps
package tccw_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;
    localparam int CELL_AW      = 13;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP    = 8'h90;
    localparam logic [7:0] CH_RIGHT = 8'h91;
    localparam logic [7:0] CH_DOWN  = 8'h92;
    localparam logic [7:0] CH_LEFT  = 8'h93;
    localparam logic [7:0] CH_HOME  = 8'h94;
    localparam logic [7:0] CH_DEL   = 8'h99;

    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_ATTR = 2'd2;

    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  char_code;
        logic [12:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [12:0] cursor_offset;
        logic [31:0] cell_data;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,     // power-up clearing pass
        ST_IDLE,
        ST_GEOM,      // clamp cursor, then dispatch
        ST_MUL,       // cursor offset via shared add loop
        ST_READ,
        ST_READ_WAIT,
        ST_PUT,       // write one plain cell and advance
        ST_COPY_RD,   // read source cell of a shift
        ST_COPY_WR,   // write it to destination
        ST_FILL,      // blank cells from addr to end
        ST_OUT
    } state_t;

    function automatic logic [8:0] screen_code(input logic [7:0] b);
        logic [8:0] v;
        v = {1'b1, b};
        if (b == 8'h5B) v = 9'h01B;
        else if (b == 8'h5D) v = 9'h01D;
        else if (v[5] && v[6]) v = v & 9'h19F;
        return v;
    endfunction

endpackage

>>> rtl/core/text_console_char_writer.sv
// Top level of the text console character writer: control sequencer and cell memory.
// Depends on tccw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// After reset the block sweeps the cell memory to zero, one cell a cycle,
// and accepts no item meanwhile; configuration writes are taken at all
// times. Every item then takes the cursor offset computation (one add per
// cursor row) plus its own work through the single-port cell memory: a plain
// character writes one cell, an in-range read fetches one cell, tab makes four
// plain writes, a delete or backspace shifts the rest of the row left by one
// cell, scroll copies every row up by one and blanks the last row, and form
// feed blanks every cell in use. The row part of the cursor offset is summed
// by the one shared adder that also walks memory addresses; the walk bounds
// come from a small rows-by-columns product.
module text_console_char_writer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tccw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tccw_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [21:0]         cfg_data
);
    localparam int MAX_COLS = tccw_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int AW       = tccw_pkg::CELL_AW;

    logic [31:0] mem [CELLS];
    logic [31:0] rdata_reg;

    logic [7:0]  cols_cfg_reg;
    logic [6:0]  rows_cfg_reg;
    logic [21:0] attr_reg;

    tccw_pkg::state_t state_reg, state_next;
    tccw_pkg::in_item_t item_reg, item_next;
    logic [5:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic [7:0]  gcols_reg, gcols_next;
    logic [6:0]  grows_reg, grows_next;
    logic [AW-1:0] addr_reg, addr_next;     // shared walking address / accumulator
    logic [AW-1:0] end_reg, end_next;       // copy: exclusive end, fill: last cell
    logic [5:0]  cnt_reg, cnt_next;         // row count for offset
    logic        skip_reg, skip_next;       // backspace at column 0 does nothing
    logic [2:0]  tabs_reg, tabs_next;
    logic [AW-1:0] off_reg, off_next;
    logic        scroll_reg, scroll_next;   // a scroll fill follows the copy
    logic [31:0] data_reg, data_next;

    // Shared adder.
    logic [AW-1:0] add_a, add_b, add_y;
    assign add_y = add_a + add_b;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;

    logic [31:0] blank;
    assign blank = {attr_reg, 1'b0, tccw_pkg::screen_code(tccw_pkg::CH_SPACE)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 8'd84;
            rows_cfg_reg <= 7'd31;
            attr_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tccw_pkg::REG_COLS: cols_cfg_reg <= cfg_data[7:0];
                tccw_pkg::REG_ROWS: rows_cfg_reg <= cfg_data[6:0];
                tccw_pkg::REG_ATTR: attr_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tccw_pkg::ST_CLEAR;
            row_reg    <= '0;
            col_reg    <= '0;
            addr_reg   <= '0;
            end_reg    <= '0;
            cnt_reg    <= '0;
            tabs_reg   <= '0;
            scroll_reg <= 1'b0;
            gcols_reg  <= 8'd2;
            grows_reg  <= 7'd1;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            addr_reg   <= addr_next;
            end_reg    <= end_next;
            cnt_reg    <= cnt_next;
            tabs_reg   <= tabs_next;
            scroll_reg <= scroll_next;
            gcols_reg  <= gcols_next;
            grows_reg  <= grows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        skip_reg <= skip_next;
        off_reg  <= off_next;
        data_reg <= data_next;
    end

    logic [AW-1:0] gc_ext, copy_end, fill_last;
    assign gc_ext    = AW'(gcols_reg);
    // First cell of the last row, and last cell in use.
    assign copy_end  = AW'(14'(grows_reg - 7'd1) * 14'(gcols_reg));
    assign fill_last = AW'(14'(grows_reg) * 14'(gcols_reg) - 14'd1);

    // Next state and datapath.
    always_comb
    begin
        logic [7:0] cc;
        state_next  = state_reg;
        item_next   = item_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        gcols_next  = gcols_reg;
        grows_next  = grows_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        skip_next   = skip_reg;
        tabs_next   = tabs_reg;
        off_next    = off_reg;
        scroll_next = scroll_reg;
        data_next   = data_reg;
        add_a       = addr_reg;
        add_b       = AW'(1);
        cc          = item_reg.char_code;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                addr_next = add_y;
                if (addr_reg == AW'(CELLS - 1)) state_next = tccw_pkg::ST_IDLE;
            end
            tccw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    if (cols_cfg_reg < 8'd2) gcols_next = 8'd2;
                    else if (32'(cols_cfg_reg) > MAX_COLS) gcols_next = 8'(MAX_COLS);
                    else gcols_next = cols_cfg_reg;
                    if (rows_cfg_reg < 7'd1) grows_next = 7'd1;
                    else if (32'(rows_cfg_reg) > MAX_ROWS) grows_next = 7'(MAX_ROWS);
                    else grows_next = rows_cfg_reg;
                    state_next = tccw_pkg::ST_GEOM;
                end
            end
            tccw_pkg::ST_GEOM:
            begin
                logic [6:0] c;
                logic [5:0] r;
                c = (8'(col_reg) >= gcols_reg) ? 7'(gcols_reg - 8'd1) : col_reg;
                r = (7'(row_reg) >= grows_reg) ? 6'(grows_reg - 7'd1) : row_reg;
                col_next  = c;
                row_next  = r;
                data_next = '0;
                tabs_next = 3'd0;
                skip_next = (cc == tccw_pkg::CH_BS) && (c == 7'd0);
                if (item_reg.cmd == tccw_pkg::CMD_READ)
                begin
                    cnt_next = '0;
                    if (32'(item_reg.read_index) < CELLS)
                    begin
                        addr_next  = item_reg.read_index;
                        state_next = tccw_pkg::ST_READ;
                    end
                    else
                    begin
                        addr_next  = '0;
                        cnt_next   = r;
                        state_next = tccw_pkg::ST_MUL;
                    end
                end
                else
                begin
                    case (cc)
                        tccw_pkg::CH_CR: col_next = '0;
                        tccw_pkg::CH_RIGHT:
                            if (8'(c) + 8'd1 < gcols_reg) col_next = c + 7'd1;
                        tccw_pkg::CH_UP: if (r != 6'd0) row_next = r - 6'd1;
                        tccw_pkg::CH_LEFT: if (c != 7'd0) col_next = c - 7'd1;
                        tccw_pkg::CH_DOWN:
                            if (7'(r) + 7'd1 < grows_reg) row_next = r + 6'd1;
                        tccw_pkg::CH_HOME:
                        begin
                            if (c == 7'd0) row_next = '0;
                            col_next = '0;
                        end
                        tccw_pkg::CH_BS: if (c != 7'd0) col_next = c - 7'd1;
                        tccw_pkg::CH_FF:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        tccw_pkg::CH_TAB: tabs_next = 3'd4;
                        default: ;
                    endcase
                    // Offset of the start of the (possibly new) cursor row.
                    addr_next  = '0;
                    cnt_next   = r;
                    state_next = tccw_pkg::ST_MUL;
                    if (cc == tccw_pkg::CH_FF || (cc == tccw_pkg::CH_HOME && c == 7'd0))
                        cnt_next = '0;
                    if (cc == tccw_pkg::CH_UP && r != 6'd0) cnt_next = r - 6'd1;
                    if ((cc == tccw_pkg::CH_DOWN || cc == tccw_pkg::CH_LF) &&
                        7'(r) + 7'd1 < grows_reg)
                        cnt_next = r + 6'd1;
                end
            end
            tccw_pkg::ST_MUL:
            begin
                // addr accumulates cnt rows of gcols.
                if (cnt_reg != 6'd0)
                begin
                    add_b     = gc_ext;
                    addr_next = add_y;
                    cnt_next  = cnt_reg - 6'd1;
                end
                else
                begin
                    off_next   = addr_reg + AW'(col_reg);
                    state_next = tccw_pkg::ST_OUT;
                    if (item_reg.cmd != tccw_pkg::CMD_READ)
                    begin
                        case (cc)
                            tccw_pkg::CH_CR, tccw_pkg::CH_RIGHT, tccw_pkg::CH_UP,
                            tccw_pkg::CH_LEFT, tccw_pkg::CH_DOWN, tccw_pkg::CH_HOME: ;
                            tccw_pkg::CH_LF:
                            begin
                                if (7'(row_reg) + 7'd1 < grows_reg)
                                    row_next = row_reg + 6'd1;
                                else
                                begin
                                    addr_next   = '0;
                                    end_next    = copy_end;
                                    scroll_next = 1'b1;
                                    state_next  = tccw_pkg::ST_COPY_RD;
                                end
                            end
                            tccw_pkg::CH_FF:
                            begin
                                addr_next  = '0;
                                end_next   = fill_last;
                                state_next = tccw_pkg::ST_FILL;
                            end
                            tccw_pkg::CH_DEL, tccw_pkg::CH_BS:
                            begin
                                if (!skip_reg)
                                begin
                                    addr_next   = addr_reg + AW'(col_reg);
                                    end_next    = addr_reg + gc_ext - AW'(1);
                                    scroll_next = 1'b0;
                                    state_next  = tccw_pkg::ST_COPY_RD;
                                end
                            end
                            default:
                            begin
                                addr_next  = addr_reg + AW'(col_reg);
                                state_next = tccw_pkg::ST_PUT;
                            end
                        endcase
                    end
                end
            end
            tccw_pkg::ST_READ: state_next = tccw_pkg::ST_READ_WAIT;
            tccw_pkg::ST_READ_WAIT:
            begin
                data_next = rdata_reg;
                addr_next = '0;
                cnt_next  = row_reg;
                state_next = tccw_pkg::ST_MUL;
            end
            tccw_pkg::ST_PUT:
            begin
                // Cell written by the memory port block; advance cursor.
                if (8'(col_reg) + 8'd1 < gcols_reg)
                begin
                    col_next  = col_reg + 7'd1;
                    addr_next = add_y;
                    off_next  = add_y;
                    state_next = (tabs_reg > 3'd1) ? tccw_pkg::ST_PUT : tccw_pkg::ST_OUT;
                end
                else
                begin
                    col_next = '0;
                    if (7'(row_reg) + 7'd1 < grows_reg)
                    begin
                        row_next   = row_reg + 6'd1;
                        addr_next  = add_y;
                        off_next   = add_y;
                        state_next = (tabs_reg > 3'd1) ? tccw_pkg::ST_PUT : tccw_pkg::ST_OUT;
                    end
                    else
                    begin
                        // Scroll; the cursor continues from the last row start.
                        off_next    = addr_reg + AW'(1) - gc_ext;
                        addr_next   = '0;
                        end_next    = copy_end;
                        scroll_next = 1'b1;
                        state_next  = tccw_pkg::ST_COPY_RD;
                    end
                end
                if (tabs_reg != 3'd0) tabs_next = tabs_reg - 3'd1;
            end
            tccw_pkg::ST_COPY_RD:
            begin
                // Source is one row below for a scroll, one cell right for a shift.
                if (scroll_reg) add_b = gc_ext;
                if (addr_reg >= end_reg)
                begin
                    end_next   = add_y - AW'(1);
                    state_next = tccw_pkg::ST_FILL;
                end
                else state_next = tccw_pkg::ST_COPY_WR;
            end
            tccw_pkg::ST_COPY_WR:
            begin
                addr_next  = add_y;
                state_next = tccw_pkg::ST_COPY_RD;
            end
            tccw_pkg::ST_FILL:
            begin
                addr_next = add_y;
                if (addr_reg == end_reg)
                begin
                    scroll_next = 1'b0;
                    if (scroll_reg && tabs_reg != 3'd0)
                    begin
                        addr_next  = off_reg;
                        state_next = tccw_pkg::ST_PUT;
                    end
                    else state_next = tccw_pkg::ST_OUT;
                end
            end
            tccw_pkg::ST_OUT:
                if (out_ready) state_next = tccw_pkg::ST_IDLE;
            default: state_next = tccw_pkg::ST_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wdata = blank;
        re    = 1'b0;
        raddr = addr_reg;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                wdata = '0;
            end
            tccw_pkg::ST_READ: re = 1'b1;
            tccw_pkg::ST_PUT:
            begin
                we    = 1'b1;
                wdata = {attr_reg, 1'b0,
                         tccw_pkg::screen_code((tabs_reg != 3'd0) ? tccw_pkg::CH_SPACE
                                                                   : item_reg.char_code)};
            end
            tccw_pkg::ST_COPY_RD:
            begin
                re    = 1'b1;
                raddr = add_y;
            end
            tccw_pkg::ST_COPY_WR:
            begin
                we    = 1'b1;
                wdata = rdata_reg;
            end
            tccw_pkg::ST_FILL: we = 1'b1;
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == tccw_pkg::ST_IDLE);
    assign out_valid = (state_reg == tccw_pkg::ST_OUT);
    assign out_data.cursor_row    = row_reg;
    assign out_data.cursor_col    = col_reg;
    assign out_data.cursor_offset = off_reg;
    assign out_data.cell_data     = data_reg;

    `ASSERT_IMPLY(a_one_side, clk, rst_n, 1'b1, !(in_ready && out_valid), "ready while result pending")
    `ASSERT_NEXT(a_out_to_idle, clk, rst_n, out_valid && out_ready, in_ready, "no return to idle")
    `ASSERT_IMPLY(a_col_range, clk, rst_n, out_valid, 8'(out_data.cursor_col) < gcols_reg, "column out of range")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for text_console_char_writer: directed and random items.
// It predicts every result itself and compares them in order. Depends on tccw_pkg.
`timescale 1ns / 1ps
module tb_top;

    localparam int CELLS = tccw_pkg::MAX_COLS_DEF * tccw_pkg::MAX_ROWS_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tccw_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tccw_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = tccw_pkg::REG_COLS;
    logic [21:0] cfg_data = '0;

    text_console_char_writer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the console state.
    logic [7:0] sh_cols = 8'd84;
    logic [6:0] sh_rows = 7'd31;
    logic [21:0] sh_attr = '0;
    int unsigned crow = 0, ccol = 0, gcols, grows;
    logic [31:0] screen [CELLS];

    tccw_pkg::in_item_t pending [$];
    tccw_pkg::out_item_t cursor_reports [$];
    int send_idle = 29, recv_idle = 66;
    bit in_fire = 1'b0;
    int errors = 0, checked = 0, reads_done = 0, scrolls = 0;

    function automatic logic [8:0] glyph(input logic [7:0] b);
        logic [8:0] v;
        v = {1'b1, b};
        if (b == 8'h5B) v = 9'h01B;
        else if (b == 8'h5D) v = 9'h01D;
        else if (v[6] && v[5]) v[6:5] = 2'b00;
        return v;
    endfunction

    function logic [31:0] blank();
        return {sh_attr, 1'b0, glyph(tccw_pkg::CH_SPACE)};
    endfunction

    function void advance_row();
        int unsigned n;
        if (crow + 1 < grows) crow++;
        else begin
            scrolls++;
            for (n = 0; n < gcols * (grows - 1); n++) screen[n] = screen[n + gcols];
            for (n = 0; n < gcols; n++) screen[gcols * (grows - 1) + n] = blank();
        end
    endfunction

    function void delete_at_cursor();
        int unsigned n, base;
        base = crow * gcols;
        for (n = ccol; n + 1 < gcols; n++) screen[base + n] = screen[base + n + 1];
        screen[base + gcols - 1] = blank();
    endfunction

    function void type_char(input logic [7:0] b);
        screen[crow * gcols + ccol] = {sh_attr, 1'b0, glyph(b)};
        if (ccol + 1 < gcols) ccol++;
        else begin
            ccol = 0;
            advance_row();
        end
    endfunction

    function tccw_pkg::out_item_t console_step(input tccw_pkg::in_item_t it);
        tccw_pkg::out_item_t r;
        int unsigned n;
        r = '0;
        gcols = (sh_cols < 2) ? 2 : (sh_cols > tccw_pkg::MAX_COLS_DEF ?
                                     tccw_pkg::MAX_COLS_DEF : sh_cols);
        grows = (sh_rows < 1) ? 1 : (sh_rows > tccw_pkg::MAX_ROWS_DEF ?
                                     tccw_pkg::MAX_ROWS_DEF : sh_rows);
        if (ccol >= gcols) ccol = gcols - 1;
        if (crow >= grows) crow = grows - 1;
        if (it.cmd == tccw_pkg::CMD_READ) begin
            r.cell_data = screen[it.read_index];
            reads_done++;
        end else begin
            case (it.char_code)
                tccw_pkg::CH_CR: ccol = 0;
                tccw_pkg::CH_LF: advance_row();
                tccw_pkg::CH_RIGHT: if (ccol + 1 < gcols) ccol++;
                tccw_pkg::CH_UP: if (crow > 0) crow--;
                tccw_pkg::CH_LEFT: if (ccol > 0) ccol--;
                tccw_pkg::CH_DOWN: if (crow + 1 < grows) crow++;
                tccw_pkg::CH_HOME:
                begin
                    if (ccol == 0) crow = 0;
                    ccol = 0;
                end
                tccw_pkg::CH_DEL: delete_at_cursor();
                tccw_pkg::CH_BS:
                    if (ccol > 0)
                    begin
                        ccol--;
                        delete_at_cursor();
                    end
                tccw_pkg::CH_FF:
                begin
                    for (n = 0; n < grows * gcols; n++) screen[n] = blank();
                    crow = 0;
                    ccol = 0;
                end
                tccw_pkg::CH_TAB: for (n = 0; n < 4; n++) type_char(tccw_pkg::CH_SPACE);
                default: type_char(it.char_code);
            endcase
        end
        r.cursor_row = crow[5:0];
        r.cursor_col = ccol[6:0];
        r.cursor_offset = 13'(crow * gcols + ccol);
        return r;
    endfunction

    // Input driver: a held item stays until it is taken.
    always @(posedge clk) begin
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready) cursor_reports.push_back(console_step(in_data));
    end

    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_fire)) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                in_data <= pending.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Result monitor.
    always @(posedge clk) begin
        tccw_pkg::out_item_t want;
        if (out_valid && out_ready) begin
            if (cursor_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %h", out_data);
            end else begin
                want = cursor_reports.pop_front();
                checked++;
                if (out_data.cursor_row !== want.cursor_row
                    || out_data.cursor_col !== want.cursor_col
                    || out_data.cursor_offset !== want.cursor_offset
                    || out_data.cell_data !== want.cell_data) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d row %0d/%0d col %0d/%0d off %0d/%0d data %h/%h",
                                 checked, out_data.cursor_row, want.cursor_row,
                                 out_data.cursor_col, want.cursor_col,
                                 out_data.cursor_offset, want.cursor_offset,
                                 out_data.cell_data, want.cell_data);
                end
            end
        end
    end

    task automatic queue_put(input logic [7:0] c);
        tccw_pkg::in_item_t it;
        it = '0;
        it.char_code = c;
        it.read_index = 13'($urandom);
        pending.push_back(it);
    endtask

    task automatic queue_read(input logic [12:0] idx);
        tccw_pkg::in_item_t it;
        it.cmd = tccw_pkg::CMD_READ;
        it.char_code = 8'($urandom);
        it.read_index = idx;
        pending.push_back(it);
    endtask

    task automatic drain();
        do @(negedge clk); while (pending.size() != 0 || in_valid || cursor_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tccw_pkg::REG_COLS: sh_cols = val[7:0];
            tccw_pkg::REG_ROWS: sh_rows = val[6:0];
            default: sh_attr = val;
        endcase
    endtask

    task automatic random_items(input int count, input int span);
        logic [7:0] ctl [12];
        int k;
        ctl = '{tccw_pkg::CH_CR, tccw_pkg::CH_LF, tccw_pkg::CH_RIGHT, tccw_pkg::CH_UP,
                tccw_pkg::CH_LEFT, tccw_pkg::CH_DOWN, tccw_pkg::CH_HOME, tccw_pkg::CH_DEL,
                tccw_pkg::CH_BS, tccw_pkg::CH_FF, tccw_pkg::CH_TAB, tccw_pkg::CH_CR};
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: queue_put(8'($urandom));
                4, 5, 6: queue_put(ctl[$urandom_range(11)]);
                7: queue_read(13'($urandom));
                default: queue_read(13'($urandom_range(span - 1)));
            endcase
        end
    endtask

    initial begin
        int ph, cols, rows;
        logic [7:0] firsts [16];
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset geometry.
        firsts = '{8'h00, 8'hFF, 8'h5B, 8'h5D, 8'h60, 8'h7F, tccw_pkg::CH_TAB,
                   tccw_pkg::CH_BS, tccw_pkg::CH_LEFT, tccw_pkg::CH_DEL,
                   tccw_pkg::CH_RIGHT, tccw_pkg::CH_DOWN, tccw_pkg::CH_UP,
                   tccw_pkg::CH_LF, tccw_pkg::CH_CR, tccw_pkg::CH_HOME};
        foreach (firsts[i]) queue_put(firsts[i]);
        queue_put(tccw_pkg::CH_HOME);
        queue_read(13'd0);
        queue_read(13'd1);
        queue_read(13'd8191);
        queue_put(tccw_pkg::CH_FF);
        queue_read(13'd2603);
        drain();

        // Oversized geometry clamps to the largest screen; run down into a scroll.
        write_reg(tccw_pkg::REG_COLS, 22'd255);
        write_reg(tccw_pkg::REG_ROWS, 22'd127);
        write_reg(tccw_pkg::REG_ATTR, 22'h3FFFFF);
        for (int i = 0; i < 66; i++) queue_put(tccw_pkg::CH_LF);
        queue_put(8'h41);
        queue_put(tccw_pkg::CH_FF);
        queue_read(13'd8191);
        queue_read(13'd8063);
        drain();

        // The form feed above left the cursor at the top left for the small screens that follow.
        for (ph = 0; ph < 9; ph++) begin
            send_idle = (ph < 3) ? 29 : (ph < 6) ? 66 : 0;
            recv_idle = (ph < 3) ? 66 : (ph < 6) ? 29 : 0;
            if (ph == 0) begin
                cols = 0;
                rows = 0;
            end else if (ph == 4) begin
                cols = 2;
                rows = 1;
            end else if (ph == 8) begin
                cols = 1;
                rows = 127;
            end else begin
                cols = $urandom_range(2, 20);
                rows = $urandom_range(1, 8);
            end
            write_reg(tccw_pkg::REG_COLS, 22'(cols));
            write_reg(tccw_pkg::REG_ROWS, 22'(rows));
            write_reg(tccw_pkg::REG_ATTR, 22'($urandom));
            if (ph == 8) random_items(60, 128);
            else random_items(100, (cols < 2 ? 2 : cols) * (rows < 1 ? 1 : rows));
            drain();
        end

        $display("Checked %0d results (%0d cell reads, %0d scrolls) over several geometries.",
                 checked, reads_done, scrolls);
        if (errors == 0)
            $display("text_console_char_writer test passed");
        else
            $display("text_console_char_writer test failed");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results still outstanding.", cursor_reports.size());
        $display("text_console_char_writer test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tccw_pkg.sv
rtl/core/text_console_char_writer.sv
sim/tb_top.sv
